// ===== rtl/sid_pkg.sv =====
package sid_pkg;

   // field and state widths
   localparam int INDEX_BITS     = 24;
   localparam int SAMPLE_BITS    = 32;
   localparam int THRESH_BITS    = 32;
   localparam int MIN_RUN_BITS   = 16;
   localparam int RUN_BITS       = 25;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 32;

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUIET_THRESHOLD = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_RUN_SAMPLES = CSR_INDEX_BITS'(1);

   // register values after reset
   localparam logic [THRESH_BITS-1:0]  QUIET_THRESHOLD_RESET = THRESH_BITS'(1000);
   localparam logic [MIN_RUN_BITS-1:0] MIN_RUN_SAMPLES_RESET = MIN_RUN_BITS'(4410);

   // largest index and largest run length; both counters stop there
   localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};
   localparam logic [RUN_BITS-1:0]   RUN_MAX   = {RUN_BITS{1'b1}};

   typedef logic [INDEX_BITS-1:0]          index_type;
   typedef logic signed [SAMPLE_BITS-1:0]  sample_type;
   typedef logic [RUN_BITS-1:0]            run_type;
   typedef logic [CSR_INDEX_BITS-1:0]      csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]       csr_data_type;

   typedef struct packed {
      sample_type sample_value;
      logic       is_last;
   } req_item_type;

   typedef struct packed {
      index_type start_index;
      index_type end_index;
   } rsp_item_type;

   typedef struct packed {
      logic [THRESH_BITS-1:0]  quiet_threshold;
      logic [MIN_RUN_BITS-1:0] min_run_samples;
   } cfg_type;

endpackage

// ===== rtl/sid_chan_if.sv =====
interface sid_req_if;
   logic                valid;
   logic                ready;
   sid_pkg::sample_type sample_value;
   logic                is_last;

   modport source (output valid, sample_value, is_last, input ready);
   modport sink (input valid, sample_value, is_last, output ready);
endinterface

interface sid_rsp_if;
   logic               valid;
   logic               ready;
   sid_pkg::index_type start_index;
   sid_pkg::index_type end_index;

   modport source (output valid, start_index, end_index, input ready);
   modport sink (input valid, start_index, end_index, output ready);
endinterface

interface sid_csr_if;
   logic                   valid;
   logic                   ready;
   sid_pkg::csr_index_type index;
   sid_pkg::csr_data_type  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/sid_csr.sv =====
module sid_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_valid,
   input  sid_pkg::csr_index_type wr_index,
   input  sid_pkg::csr_data_type  wr_data,
   output sid_pkg::cfg_type       cfg
);

   sid_pkg::cfg_type cfg_ff;
   sid_pkg::cfg_type cfg_in;

   // decode the write; unknown indexes leave the registers alone
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         unique case (wr_index)
            sid_pkg::CSR_QUIET_THRESHOLD:
               cfg_in.quiet_threshold = wr_data[sid_pkg::THRESH_BITS-1:0];
            sid_pkg::CSR_MIN_RUN_SAMPLES:
               cfg_in.min_run_samples = wr_data[sid_pkg::MIN_RUN_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quiet_threshold <= sid_pkg::QUIET_THRESHOLD_RESET;
         cfg_ff.min_run_samples <= sid_pkg::MIN_RUN_SAMPLES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/sid_in_stage.sv =====
module sid_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sid_pkg::req_item_type req_item,
   input  logic                  step,
   output logic                  item_valid,
   output sid_pkg::req_item_type item
);

   logic                  valid_ff;
   logic                  valid_in;
   sid_pkg::req_item_type item_ff;
   logic                  load;

   // take a new request when the slot is empty or drains this cycle
   assign req_ready = !valid_ff || step;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the payload until the core takes it
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/sid_core.sv =====
module sid_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  sid_pkg::req_item_type item,
   input  sid_pkg::cfg_type      cfg,
   output logic                  emit,
   output sid_pkg::rsp_item_type result
);

   sid_pkg::index_type counter_ff, counter_in;
   sid_pkg::index_type start_ff, start_in;
   sid_pkg::run_type   length_ff, length_in;

   logic [sid_pkg::SAMPLE_BITS-1:0] raw;
   logic [sid_pkg::SAMPLE_BITS-1:0] magnitude;
   logic                            quiet;
   sid_pkg::run_type                min_run;
   sid_pkg::index_type              run_start;
   sid_pkg::run_type                run_length;

   // classify the sample and advance the current quiet run
   always_comb begin
      raw        = $unsigned(item.sample_value);
      magnitude  = raw[sid_pkg::SAMPLE_BITS-1] ? (~raw + sid_pkg::SAMPLE_BITS'(1)) : raw;
      quiet      = magnitude < cfg.quiet_threshold;
      min_run    = sid_pkg::RUN_BITS'(cfg.min_run_samples);
      run_start  = start_ff;
      run_length = length_ff;
      emit       = 1'b0;

      if (quiet) begin
         if (length_ff == '0) begin
            run_start = counter_ff;
         end
         if (length_ff != sid_pkg::RUN_MAX) begin
            run_length = length_ff + sid_pkg::RUN_BITS'(1);
         end
         emit = item.is_last && (run_length > min_run);
      end else begin
         emit       = length_ff > min_run;
         run_length = '0;
      end

      result.start_index = run_start;
      result.end_index   = counter_ff;
   end

   // end of recording restarts the index; otherwise count up and stop at the top
   always_comb begin
      counter_in = counter_ff;
      start_in   = start_ff;
      length_in  = length_ff;
      if (step) begin
         if (item.is_last) begin
            counter_in = '0;
            start_in   = '0;
            length_in  = '0;
         end else begin
            start_in  = run_start;
            length_in = run_length;
            if (counter_ff != sid_pkg::INDEX_MAX) begin
               counter_in = counter_ff + sid_pkg::INDEX_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         start_ff   <= '0;
         length_ff  <= '0;
      end else begin
         counter_ff <= counter_in;
         start_ff   <= start_in;
         length_ff  <= length_in;
      end
   end

endmodule

// ===== rtl/sid_out_stage.sv =====
module sid_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  emit,
   input  sid_pkg::rsp_item_type result,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sid_pkg::rsp_item_type rsp_item
);

   logic                  valid_ff;
   logic                  valid_in;
   sid_pkg::rsp_item_type item_ff;

   // the core may step when the slot is empty or is taken this cycle
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (step) begin
         valid_in = emit;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // capture an interval only when the step produces one
   always_ff @(posedge clock) begin
      if (step && emit) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

// ===== rtl/silence_interval_detect_top.sv =====
// A request held in the input register passes the compare-and-count step into the
// result register once that is free. Throughput: one request per cycle while the
// result register is free, set by the single step between the two registers.
// Reset: synchronous, active high; clears the sample index and run, empties both
// registers and restores the threshold and minimum run to their defaults.
module silence_interval_detect_top (
   input  logic      clock,
   input  logic      reset,
   sid_req_if.sink   req_bus,
   sid_rsp_if.source rsp_bus,
   sid_csr_if.sink   csr_bus
);

   sid_pkg::cfg_type      cfg;
   sid_pkg::req_item_type req_item;
   sid_pkg::req_item_type item;
   sid_pkg::rsp_item_type result;
   sid_pkg::rsp_item_type rsp_item;
   logic                  item_valid;
   logic                  out_free;
   logic                  step;
   logic                  emit;

   // configuration writes always complete at once
   assign csr_bus.ready = 1'b1;

   sid_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg)
   );

   assign req_item.sample_value = req_bus.sample_value;
   assign req_item.is_last      = req_bus.is_last;

   sid_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_item   (req_item),
      .step       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   // advance a held request once the result slot can take it
   assign step = item_valid && out_free;

   sid_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .cfg    (cfg),
      .emit   (emit),
      .result (result)
   );

   sid_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .emit      (emit),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_bus.start_index = rsp_item.start_index;
   assign rsp_bus.end_index   = rsp_item.end_index;

endmodule

// ===== rtl/sid_checker.sv =====
module sid_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input sid_pkg::index_type start_index,
   input sid_pkg::index_type end_index
);

   // a stalled interval stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("interval withdrawn while stalled");

   // a stalled interval keeps its indices
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(start_index) && $stable(end_index))
      else $error("interval changed while stalled");

   // an interval never ends before it starts
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> end_index >= start_index)
      else $error("interval end precedes its start");

   // a fresh interval follows a request taken earlier
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("interval without a matching request");

   // reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("interval offered straight after reset");

endmodule

bind silence_interval_detect_top sid_checker u_sid_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .start_index (rsp_bus.start_index),
   .end_index   (rsp_bus.end_index)
);
